FILE: src/hc2_pkg.sv
// hc2_pkg: shared types, register indexes and mod 26 arithmetic for the
// 2x2 Hill cipher core. No dependencies; imported by every module.
package hc2_pkg;

    localparam int unsigned LW = 5;  // letter and key entry width
    localparam int unsigned CIW = 3; // configuration index width

    // Configuration register indexes
    localparam logic [CIW-1:0] CFG_KEY_00 = 3'd0;
    localparam logic [CIW-1:0] CFG_KEY_01 = 3'd1;
    localparam logic [CIW-1:0] CFG_KEY_10 = 3'd2;
    localparam logic [CIW-1:0] CFG_KEY_11 = 3'd3;
    localparam logic [CIW-1:0] CFG_MODE   = 3'd4;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam logic [LW-1:0] MODULUS = 5'd26;
    // ceil(2^16 / 26); exact floor quotient for every value below 2048
    localparam logic [11:0] RECIP26 = 12'd2521;

    // Active matrix and its singular flag
    typedef struct packed {
        logic [LW-1:0] m00;
        logic [LW-1:0] m01;
        logic [LW-1:0] m10;
        logic [LW-1:0] m11;
        logic          err;
    } t_matrix;

    // One result beat
    typedef struct packed {
        logic [LW-1:0] letter;
        logic          last;
        logic          err;
    } t_result;

    // Reduce a 5-bit code into 0..25
    function automatic logic [LW-1:0] red26(input logic [LW-1:0] x);
        return (x >= MODULUS) ? x - MODULUS : x;
    endfunction

    // x mod 26 for x below 2048, by reciprocal multiply
    function automatic logic [LW-1:0] mod26(input logic [10:0] x);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [11:0] qm;
        logic [10:0] r;
        prod = 23'(x) * 23'(RECIP26);
        q    = prod[22:16];
        qm   = 12'(q) * 12'(MODULUS);
        r    = x - qm[10:0];
        return r[LW-1:0];
    endfunction

    // Multiplicative inverse mod 26: {found, inverse}
    function automatic logic [LW:0] inv26(input logic [LW-1:0] d);
        logic [LW:0] res;
        case (d)
            5'd1:    res = {1'b1, 5'd1};
            5'd3:    res = {1'b1, 5'd9};
            5'd5:    res = {1'b1, 5'd21};
            5'd7:    res = {1'b1, 5'd15};
            5'd9:    res = {1'b1, 5'd3};
            5'd11:   res = {1'b1, 5'd19};
            5'd15:   res = {1'b1, 5'd7};
            5'd17:   res = {1'b1, 5'd23};
            5'd19:   res = {1'b1, 5'd11};
            5'd21:   res = {1'b1, 5'd5};
            5'd23:   res = {1'b1, 5'd17};
            5'd25:   res = {1'b1, 5'd25};
            default: res = {1'b0, 5'd0};
        endcase
        return res;
    endfunction

endpackage

FILE: src/hc2_key_unit.sv
// hc2_key_unit: configuration registers and the registered active matrix
// (key or inverse key). Depends on hc2_pkg.
module hc2_key_unit
    import hc2_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CIW-1:0]  i_cfg_index,
    input  logic [LW-1:0]   i_cfg_data,
    output t_matrix         o_mat
);

    logic [LW-1:0] r_key00, r_key01, r_key10, r_key11;
    logic          r_mode;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key00 <= 5'd1;
            r_key01 <= 5'd0;
            r_key10 <= 5'd0;
            r_key11 <= 5'd1;
            r_mode  <= MODE_ENCRYPT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_00: r_key00 <= i_cfg_data;
                CFG_KEY_01: r_key01 <= i_cfg_data;
                CFG_KEY_10: r_key10 <= i_cfg_data;
                CFG_KEY_11: r_key11 <= i_cfg_data;
                CFG_MODE:   r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage 1: reduce entries and form the determinant mod 26
    logic [LW-1:0] a, b, c, d;
    logic [10:0]   n_det_sum;
    logic [LW-1:0] r_a, r_b, r_c, r_d, r_det;
    logic          r_s1_mode;

    always_comb begin
        a = red26(r_key00);
        b = red26(r_key01);
        c = red26(r_key10);
        d = red26(r_key11);
        n_det_sum = 11'(a) * 11'(d) + 11'd676 - 11'(b) * 11'(c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a       <= 5'd1;
            r_b       <= 5'd0;
            r_c       <= 5'd0;
            r_d       <= 5'd1;
            r_det     <= 5'd1;
            r_s1_mode <= MODE_ENCRYPT;
        end else begin
            r_a       <= a;
            r_b       <= b;
            r_c       <= c;
            r_d       <= d;
            r_det     <= mod26(n_det_sum);
            r_s1_mode <= r_mode;
        end
    end

    // Stage 2: adjugate times inverse determinant, or the key itself
    logic [LW:0]   inv_res;
    logic [LW-1:0] inv, neg_b, neg_c;
    t_matrix       n_mat, r_mat;

    always_comb begin
        inv_res = inv26(r_det);
        inv     = inv_res[LW-1:0];
        neg_b   = (r_b == '0) ? '0 : MODULUS - r_b;
        neg_c   = (r_c == '0) ? '0 : MODULUS - r_c;
        if (r_s1_mode == MODE_DECRYPT) begin
            n_mat.m00 = mod26(11'(r_d) * 11'(inv));
            n_mat.m01 = mod26(11'(neg_b) * 11'(inv));
            n_mat.m10 = mod26(11'(neg_c) * 11'(inv));
            n_mat.m11 = mod26(11'(r_a) * 11'(inv));
            n_mat.err = ~inv_res[LW];
        end else begin
            n_mat.m00 = r_a;
            n_mat.m01 = r_b;
            n_mat.m10 = r_c;
            n_mat.m11 = r_d;
            n_mat.err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '{m00: 5'd1, m01: 5'd0, m10: 5'd0, m11: 5'd1, err: 1'b0};
        end else begin
            r_mat <= n_mat;
        end
    end

    assign o_mat = r_mat;

    // Error only comes from a decrypt setting
    a_err_needs_decrypt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mat.err |-> $past(r_s1_mode) == MODE_DECRYPT)
        else $error("key error raised in encrypt mode");

endmodule

FILE: src/hc2_pair_unit.sv
// hc2_pair_unit: pairs incoming letters into an input register and forms
// the two result letters of each pair. Depends on hc2_pkg.
module hc2_pair_unit
    import hc2_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [LW-1:0]  i_letter,
    input  logic           i_message_end,
    input  t_matrix        i_mat,
    output logic           o_pair_vld,
    output t_result        o_res0,
    output t_result        o_res1
);

    logic [LW-1:0] r_held;
    logic          r_half;
    logic          r_pair_vld;
    logic [LW-1:0] r_p0, r_p1;
    logic          r_end;
    logic [LW-1:0] letter;

    assign letter = red26(i_letter);

    // Hold the first letter; on the second or a lone final letter, load the pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_half     <= 1'b0;
            r_pair_vld <= 1'b0;
        end else begin
            r_pair_vld <= 1'b0;
            if (i_accept) begin
                if (!r_half && !i_message_end) begin
                    r_held <= letter;
                    r_half <= 1'b1;
                end else begin
                    r_held     <= '0;
                    r_half     <= 1'b0;
                    r_pair_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p0  <= r_half ? r_held : letter;
            r_p1  <= r_half ? letter : '0;
            r_end <= i_message_end;
        end
    end

    // Matrix times the pair column, mod 26
    logic [10:0] sum0, sum1;

    always_comb begin
        sum0 = 11'(i_mat.m00) * 11'(r_p0) + 11'(i_mat.m01) * 11'(r_p1);
        sum1 = 11'(i_mat.m10) * 11'(r_p0) + 11'(i_mat.m11) * 11'(r_p1);
        o_res0 = '{letter: mod26(sum0), last: 1'b0, err: i_mat.err};
        o_res1 = '{letter: mod26(sum1), last: r_end, err: i_mat.err};
    end

    assign o_pair_vld = r_pair_vld;

endmodule

FILE: src/hc2_result_fifo.sv
// hc2_result_fifo: result queue taking two beats at once and giving one
// beat per cycle while popped. Depends on hc2_pkg.
module hc2_result_fifo
    import hc2_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  t_result                     i_res0,
    input  t_result                     i_res1,
    input  logic                        i_pop,
    output t_result                     o_head,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   wr1;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
    endfunction

    assign wr1 = inc(r_wr);

    // Store both results of a pair
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res0;
            r_mem[wr1]  <= i_res1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= inc(wr1);
            end
            if (i_pop) begin
                r_rd <= inc(r_rd);
            end
            r_count <= r_count + (i_push ? CW'(2) : CW'(0)) - (i_pop ? CW'(1) : CW'(0));
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count <= CW'(DEPTH-2))
        else $error("pair pushed without room for two beats");

endmodule

FILE: src/hill_cipher_2x2_core.sv
// hill_cipher_2x2_core: 2x2 Hill cipher mod 26 on a letter stream.
// The second letter of a pair loads the pair register; its results go into
// a result queue of RES_DEPTH, second beat after first. One letter per cycle
// while results are drained and no configuration write is pending; after
// a write, the input is held off while the two-stage key unit rebuilds the
// matrix. Synchronous active-low reset restores the identity key, encrypt
// mode and an empty pair and queue.
module hill_cipher_2x2_core
    import hc2_pkg::*;
#(
    parameter int unsigned RES_DEPTH = 8   // at least 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // letter input
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [LW-1:0]    i_letter,
    input  logic             i_message_end,
    // result output
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [LW-1:0]    o_out_letter,
    output logic             o_out_last,
    output logic             o_key_error,
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CIW-1:0]   i_cfg_index,
    input  logic [LW-1:0]    i_cfg_data
);

    localparam int unsigned CW = $clog2(RES_DEPTH+1);

    logic          cfg_we, in_acc, out_acc;
    logic          r_cfg_busy;
    t_matrix       mat;
    logic          pair_vld;
    t_result       res0, res1, head;
    logic [CW-1:0] count;
    logic [CW:0]   need;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // Hold off input after a configuration write; the write is registered as busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_busy <= 1'b0;
        end else begin
            r_cfg_busy <= cfg_we;
        end
    end

    // Reserve room for a pair in flight and one that this beat may complete
    assign need = (CW+1)'(count) + (pair_vld ? (CW+1)'(4) : (CW+1)'(2));
    assign o_in_ready = !i_cfg_valid && !r_cfg_busy && (need <= (CW+1)'(RES_DEPTH));
    assign in_acc     = i_in_valid & o_in_ready;

    hc2_key_unit u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mat       (mat)
    );

    hc2_pair_unit u_pair (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_letter      (i_letter),
        .i_message_end (i_message_end),
        .i_mat         (mat),
        .o_pair_vld    (pair_vld),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    hc2_result_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pair_vld),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (out_acc),
        .o_head  (head),
        .o_count (count)
    );

    assign o_out_valid  = (count != '0);
    assign out_acc      = o_out_valid & i_out_ready;
    assign o_out_letter = head.letter;
    assign o_out_last   = head.last;
    assign o_key_error  = head.err;

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> !in_acc)
        else $error("letter taken before key matrix settled");

    a_no_cfg_with_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cfg_we && in_acc))
        else $error("letter and configuration taken together");

endmodule
